// File: rtl/msa_pkg.sv
package msa_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [16:0] side_t;
  typedef logic [1:0]  status_t;

  localparam status_t ST_DATA    = 2'd0;
  localparam status_t ST_REJECT  = 2'd1;
  localparam status_t ST_CORRUPT = 2'd2;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_TLEN   = 4'd1;
  localparam logic [3:0] PH_RAW    = 4'd2;
  localparam logic [3:0] PH_PACKED = 4'd3;
  localparam logic [3:0] PH_RVAL   = 4'd4;
  localparam logic [3:0] PH_RHI    = 4'd5;
  localparam logic [3:0] PH_RLO    = 4'd6;
  localparam logic [3:0] PH_IDLE   = 4'd7;
  localparam logic [3:0] PH_MUL    = 4'd8;

  localparam logic [1:0] MP_SECB = 2'd0;
  localparam logic [1:0] MP_TRK  = 2'd1;
  localparam logic [1:0] MP_IMG  = 2'd2;

  localparam logic [3:0] HP_SEC_HI  = 4'd2;
  localparam logic [3:0] HP_SEC_LO  = 4'd3;
  localparam logic [3:0] HP_SIDE_HI = 4'd4;
  localparam logic [3:0] HP_SIDE_LO = 4'd5;
  localparam logic [3:0] HP_STRT_HI = 4'd6;
  localparam logic [3:0] HP_STRT_LO = 4'd7;
  localparam logic [3:0] HP_END_HI  = 4'd8;
  localparam logic [3:0] HP_END_LO  = 4'd9;

  localparam byte_t RUN_MARK = 8'hE5;

endpackage

// File: rtl/msa_in_if.sv
interface msa_in_if
  import msa_pkg::*;
  ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/msa_out_if.sv
interface msa_out_if
  import msa_pkg::*;
  ();
  logic    valid;
  logic    ready;
  byte_t   out_byte;
  word_t   repeat_count;
  logic    image_done;
  status_t status;
  word_t   sectors_per_track;
  side_t   side_count;
  word_t   final_track;

  modport source (output valid, output out_byte, output repeat_count, output image_done,
                  output status, output sectors_per_track, output side_count,
                  output final_track, input ready);
  modport sink   (input valid, input out_byte, input repeat_count, input image_done,
                  input status, input sectors_per_track, input side_count,
                  input final_track, output ready);
endinterface

// File: rtl/msa_disk_image_rle_decoder_core.sv
// Streaming MSA disk-image decoder. Takes one byte of the packed file per cycle while not
// held off and gives at most one result per byte: a literal (repeat_count 1), a run (byte
// plus count, cut to the room left in the image), a completion marker (image_done, set on
// the last literal or run or on an empty result), or a status (1 rejected header, 2 corrupt
// or truncated). After the last byte of an accepted header the input stalls while one
// shift-add multiplier, one multiplier bit per cycle, forms sectors*SECTOR_BYTES,
// tracks*sides and the image size. At other times the input is held off only while a
// result waits in the output register and the output is not ready.
// State returns to reset after the byte marked in_last.
module msa_disk_image_rle_decoder_core
  import msa_pkg::*;
#(
  parameter int SECTOR_BYTES = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  msa_in_if.sink    in_ch,
  msa_out_if.source out_ch
);

  localparam int SB_W   = $clog2(SECTOR_BYTES + 1);
  localparam int SECB_W = 16 + SB_W;
  localparam int MPL_W  = SECB_W;
  localparam int IMG_W  = 33 + SECB_W;

  logic [3:0]        phase_r, phase_nxt;
  logic [3:0]        hpos_r, hpos_nxt;
  word_t             sector_r, sector_nxt;
  side_t             side_r, side_nxt;
  word_t             end_r, end_nxt;
  logic              start_nz_r, start_nz_nxt;
  logic [32:0]       tracks_left_r, tracks_left_nxt;
  word_t             tbl_r, tbl_nxt;
  logic [IMG_W-1:0]  room_r, room_nxt;
  byte_t             run_val_r, run_val_nxt;
  byte_t             run_hi_r, run_hi_nxt;
  logic [SECB_W-1:0] secb_r, secb_nxt;
  logic [1:0]        mpass_r, mpass_nxt;
  logic [IMG_W-1:0]  mcand_r, mcand_nxt;
  logic [MPL_W-1:0]  mplier_r, mplier_nxt;
  logic [IMG_W-1:0]  acc_r, acc_nxt;

  logic              out_valid_r, out_valid_nxt;
  byte_t             o_byte_r;
  word_t             o_count_r;
  logic              o_done_r;
  status_t           o_status_r;
  word_t             o_sec_r;
  side_t             o_side_r;
  word_t             o_end_r;

  logic              accept;
  byte_t             b;
  logic              have;
  byte_t             r_byte;
  word_t             r_count;
  logic              r_done;
  status_t           r_status;
  logic              fin;
  status_t           st;
  word_t             len;
  word_t             tbl_dec;
  logic [32:0]       tl_dec;
  logic [IMG_W-1:0]  want;
  logic [IMG_W-1:0]  cnt;

  assign in_ch.ready = (phase_r != PH_MUL) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign tbl_dec     = tbl_r - 16'd1;

  always_comb begin
    phase_nxt       = phase_r;
    hpos_nxt        = hpos_r;
    sector_nxt      = sector_r;
    side_nxt        = side_r;
    end_nxt         = end_r;
    start_nz_nxt    = start_nz_r;
    tracks_left_nxt = tracks_left_r;
    tbl_nxt         = tbl_r;
    room_nxt        = room_r;
    run_val_nxt     = run_val_r;
    run_hi_nxt      = run_hi_r;
    secb_nxt        = secb_r;
    mpass_nxt       = mpass_r;
    mcand_nxt       = mcand_r;
    mplier_nxt      = mplier_r;
    acc_nxt         = acc_r;
    have            = 1'b0;
    r_byte          = '0;
    r_count         = '0;
    r_done          = 1'b0;
    r_status        = ST_DATA;
    fin             = 1'b0;
    st              = ST_DATA;
    len             = tbl_r | word_t'(b);
    tl_dec          = '0;
    want            = IMG_W'({run_hi_r, b});
    cnt             = (want < room_r) ? want : room_r;

    // shared shift-add multiplier
    if (phase_r == PH_MUL) begin
      if (mplier_r == '0) begin
        acc_nxt = '0;
        case (mpass_r)
          MP_SECB: begin
            secb_nxt   = acc_r[SECB_W-1:0];
            mcand_nxt  = IMG_W'({1'b0, end_r} + 17'd1);
            mplier_nxt = MPL_W'(side_r);
            mpass_nxt  = MP_TRK;
          end
          MP_TRK: begin
            tracks_left_nxt = acc_r[32:0];
            mcand_nxt       = IMG_W'(acc_r[32:0]);
            mplier_nxt      = secb_r;
            mpass_nxt       = MP_IMG;
          end
          default: begin
            room_nxt  = acc_r;
            phase_nxt = PH_TLEN;
            hpos_nxt  = '0;
          end
        endcase
      end else begin
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
      end
    end

    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          case (hpos_r)
            HP_SEC_HI:  sector_nxt = {b, 8'h00};
            HP_SEC_LO:  sector_nxt = sector_r | word_t'(b);
            HP_SIDE_HI: side_nxt = {1'b0, b, 8'h00};
            HP_SIDE_LO: side_nxt = (side_r | side_t'(b)) + 17'd1;
            HP_STRT_HI: start_nz_nxt = (b != 8'h00);
            HP_STRT_LO: if (b != 8'h00) start_nz_nxt = 1'b1;
            HP_END_HI:  end_nxt = {b, 8'h00};
            HP_END_LO:  end_nxt = end_r | word_t'(b);
            default: ;
          endcase
          if (hpos_r >= HP_END_LO) begin
            hpos_nxt = '0;
            if (start_nz_nxt || end_nxt == '0) begin
              st = ST_REJECT;
            end else begin
              mcand_nxt  = IMG_W'(sector_nxt);
              mplier_nxt = MPL_W'(SECTOR_BYTES);
              acc_nxt    = '0;
              mpass_nxt  = MP_SECB;
              phase_nxt  = PH_MUL;
            end
          end else begin
            hpos_nxt = hpos_r + 4'd1;
          end
        end
        PH_TLEN: begin
          if (hpos_r == '0) begin
            tbl_nxt  = {b, 8'h00};
            hpos_nxt = 4'd1;
          end else begin
            hpos_nxt = '0;
            tbl_nxt  = len;
            if (SECB_W'(len) == secb_r) begin
              if (IMG_W'(len) > room_r) st = ST_CORRUPT;
              else if (len == '0) fin = 1'b1;
              else phase_nxt = PH_RAW;
            end else if (len == '0) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_PACKED;
            end
          end
        end
        PH_RAW: begin
          have     = 1'b1;
          r_byte   = b;
          r_count  = 16'd1;
          room_nxt = room_r - IMG_W'(1);
          tbl_nxt  = tbl_dec;
          if (tbl_dec == '0) fin = 1'b1;
        end
        PH_PACKED: begin
          if (room_r == '0) begin
            st = ST_CORRUPT;
          end else if (b == RUN_MARK) begin
            tbl_nxt   = tbl_dec;
            phase_nxt = PH_RVAL;
          end else begin
            have     = 1'b1;
            r_byte   = b;
            r_count  = 16'd1;
            room_nxt = room_r - IMG_W'(1);
            tbl_nxt  = tbl_dec;
            if (tbl_dec == '0) fin = 1'b1;
          end
        end
        PH_RVAL: begin
          run_val_nxt = b;
          phase_nxt   = PH_RHI;
        end
        PH_RHI: begin
          run_hi_nxt = b;
          phase_nxt  = PH_RLO;
        end
        PH_RLO: begin
          room_nxt = room_r - cnt;
          if (cnt != '0) begin
            have    = 1'b1;
            r_byte  = run_val_r;
            r_count = cnt[15:0];
          end
          tbl_nxt = (tbl_r >= 16'd3) ? (tbl_r - 16'd3) : 16'd0;
          if (tbl_nxt == '0) fin = 1'b1;
          else phase_nxt = PH_PACKED;
        end
        default: ;
      endcase

      if (fin) begin
        tl_dec          = (tracks_left_r != '0) ? (tracks_left_r - 33'd1) : tracks_left_r;
        tracks_left_nxt = tl_dec;
        if (tl_dec == '0) begin
          phase_nxt = PH_IDLE;
          have      = 1'b1;
          r_done    = 1'b1;
        end else begin
          phase_nxt = PH_TLEN;
          hpos_nxt  = '0;
        end
      end

      if (in_ch.in_last && phase_nxt != PH_IDLE && st == ST_DATA) st = ST_CORRUPT;

      if (st != ST_DATA) begin
        have      = 1'b1;
        r_byte    = '0;
        r_count   = '0;
        r_done    = 1'b0;
        r_status  = st;
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (accept && have) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.in_last)) begin
      phase_r       <= PH_HEADER;
      hpos_r        <= '0;
      sector_r      <= '0;
      side_r        <= '0;
      end_r         <= '0;
      start_nz_r    <= 1'b0;
      tracks_left_r <= '0;
      tbl_r         <= '0;
      room_r        <= '0;
      run_val_r     <= '0;
      run_hi_r      <= '0;
      secb_r        <= '0;
      mpass_r       <= MP_SECB;
    end else begin
      phase_r       <= phase_nxt;
      hpos_r        <= hpos_nxt;
      sector_r      <= sector_nxt;
      side_r        <= side_nxt;
      end_r         <= end_nxt;
      start_nz_r    <= start_nz_nxt;
      tracks_left_r <= tracks_left_nxt;
      tbl_r         <= tbl_nxt;
      room_r        <= room_nxt;
      run_val_r     <= run_val_nxt;
      run_hi_r      <= run_hi_nxt;
      secb_r        <= secb_nxt;
      mpass_r       <= mpass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    if (accept && have) begin
      o_byte_r   <= r_byte;
      o_count_r  <= r_count;
      o_done_r   <= r_done;
      o_status_r <= r_status;
      o_sec_r    <= sector_nxt;
      o_side_r   <= side_nxt;
      o_end_r    <= end_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.out_byte          = o_byte_r;
  assign out_ch.repeat_count      = o_count_r;
  assign out_ch.image_done        = o_done_r;
  assign out_ch.status            = o_status_r;
  assign out_ch.sectors_per_track = o_sec_r;
  assign out_ch.side_count        = o_side_r;
  assign out_ch.final_track       = o_end_r;

endmodule
